### rtl/go_back_n_sender_window_top_defines.svh
// Assertion macros for the Go-Back-N sender window block.
// Used by go_back_n_sender_window_top; needs aclk and aresetn in scope.
`ifndef GO_BACK_N_SENDER_WINDOW_TOP_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GBN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GBN_ASSERT_IMP(label, ante, cons, msg)
`define GBN_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### rtl/gbn_pkg.sv
// Shared types and constants for the Go-Back-N sender window block.
// No dependencies; imported by every module of the block.
package gbn_pkg;

    localparam int SEQ_BITS_DEF   = 16;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam int WIN_W   = 7;
    localparam int RETRY_W = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 7'd8;
    localparam logic [RETRY_W-1:0] RETRY_RESET  = 4'd5;
    localparam logic [RETRY_W-1:0] RETRY_SAT    = 4'd15;

    localparam logic [KIND_W-1:0] KIND_OFFER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd1;

    typedef enum logic [1:0] {
        OP_OFFER,
        OP_ACK,
        OP_TIMEOUT
    } op_t;

    typedef enum logic [2:0] {
        ACT_SEND,
        ACT_REFUSED,
        ACT_ACKED,
        ACT_DONE,
        ACT_RETX,
        ACT_ABORT,
        ACT_EMPTY,
        ACT_HALTED
    } act_t;

    typedef enum logic {
        BK_IDLE,
        BK_RETX
    } bk_state_t;

    typedef struct packed {
        op_t  op;
        logic fin;
    } cmd_ctl_t;

    typedef struct packed {
        act_t action;
        logic last;
    } res_ctl_t;

    typedef struct packed {
        logic [WIN_W-1:0]   window_size;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

endpackage

### rtl/gbn_front.sv
// Front end: takes input beats, drops unknown kinds, decodes the rest
// into commands held in one register stage. Depends on gbn_pkg.
module gbn_front #(
    parameter int SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gbn_pkg::KIND_W-1:0] in_kind,
    input  logic [SEQ_BITS-1:0]        in_ack,
    input  logic                       in_fin,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output gbn_pkg::cmd_ctl_t          cmd_ctl,
    output logic [SEQ_BITS-1:0]        cmd_ack
);
    import gbn_pkg::*;

    logic              hold_valid_reg, hold_valid_next;
    cmd_ctl_t          hold_ctl_reg, hold_ctl_next;
    logic [SEQ_BITS-1:0] hold_ack_reg;
    logic              accept;

    assign in_ready = !hold_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        hold_valid_next = (hold_valid_reg && !cmd_ready) || (accept && in_kind != KIND_NONE);
        hold_ctl_next.fin = in_fin && (in_kind == KIND_ACK);
        unique case (in_kind)
            KIND_OFFER: hold_ctl_next.op = OP_OFFER;
            KIND_ACK:   hold_ctl_next.op = OP_ACK;
            default:    hold_ctl_next.op = OP_TIMEOUT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_ctl_reg <= hold_ctl_next;
            hold_ack_reg <= in_ack;
        end
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd_ctl   = hold_ctl_reg;
    assign cmd_ack   = hold_ack_reg;

endmodule

### rtl/gbn_queue.sv
// Short command queue between front and back end.
// Depends on gbn_pkg (command type, depth).
module gbn_queue #(
    parameter int SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  gbn_pkg::cmd_ctl_t   push_ctl,
    input  logic [SEQ_BITS-1:0] push_ack,
    output logic                pop_valid,
    input  logic                pop_ready,
    output gbn_pkg::cmd_ctl_t   pop_ctl,
    output logic [SEQ_BITS-1:0] pop_ack
);
    import gbn_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_ctl_t            ctl_mem [QUEUE_DEPTH];
    logic [SEQ_BITS-1:0] ack_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ctl_mem[wr_ptr_reg] <= push_ctl;
            ack_mem[wr_ptr_reg] <= push_ack;
        end
    end

    assign pop_ctl = ctl_mem[rd_ptr_reg];
    assign pop_ack = ack_mem[rd_ptr_reg];

endmodule

### rtl/gbn_back.sv
// Back end: window state, command execution, retransmit sequencer and
// the result output register. Depends on gbn_pkg.
module gbn_back #(
    parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF,
    parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gbn_pkg::cfg_t       cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  gbn_pkg::cmd_ctl_t   cmd_ctl,
    input  logic [SEQ_BITS-1:0] cmd_ack,
    output logic                res_valid,
    input  logic                res_ready,
    output gbn_pkg::res_ctl_t   res_ctl,
    output logic [SEQ_BITS-1:0] res_seq,
    output logic [SEQ_BITS-1:0] res_base,
    output logic [SEQ_BITS-1:0] res_next
);
    import gbn_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    bk_state_t           state_reg, state_next;
    logic [SEQ_BITS-1:0] base_reg, base_next;
    logic [SEQ_BITS-1:0] next_reg, next_next;
    logic [SEQ_BITS-1:0] prior_reg, prior_next;
    logic [RETRY_W-1:0]  retry_reg, retry_next;
    logic                halted_reg, halted_next;
    logic [SEQ_BITS-1:0] retx_seq_reg, retx_seq_next;
    logic [CNT_W-1:0]    retx_left_reg, retx_left_next;

    logic                m_valid_reg, m_valid_next;
    res_ctl_t            m_ctl_reg, m_ctl_next;
    logic [SEQ_BITS-1:0] m_seq_reg, m_seq_next;
    logic [SEQ_BITS-1:0] m_base_reg, m_base_next;
    logic [SEQ_BITS-1:0] m_next_reg, m_next_next;

    logic                out_free;
    logic [SEQ_BITS-1:0] outstanding;
    logic [WIN_W-1:0]    eff_window;
    logic [RETRY_W-1:0]  retry_inc;
    logic [CNT_W-1:0]    retx_count;
    logic                emit;
    res_ctl_t            emit_ctl;
    logic [SEQ_BITS-1:0] emit_seq;

    assign out_free    = !m_valid_reg || res_ready;
    assign outstanding = next_reg - base_reg;
    assign retry_inc   = (retry_reg == RETRY_SAT) ? retry_reg : retry_reg + 1'b1;

    always_comb begin
        if (cfg.window_size == '0) begin
            eff_window = WIN_W'(1);
        end else if (cfg.window_size > WIN_W'(WINDOW_MAX)) begin
            eff_window = WIN_W'(WINDOW_MAX);
        end else begin
            eff_window = cfg.window_size;
        end
        if (outstanding > SEQ_BITS'(WINDOW_MAX)) begin
            retx_count = CNT_W'(WINDOW_MAX);
        end else begin
            retx_count = outstanding[CNT_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        next_next      = next_reg;
        prior_next     = prior_reg;
        retry_next     = retry_reg;
        halted_next    = halted_reg;
        retx_seq_next  = retx_seq_reg;
        retx_left_next = retx_left_reg;
        cmd_ready      = 1'b0;
        emit           = 1'b0;
        emit_ctl       = '{action: ACT_HALTED, last: 1'b1};
        emit_seq       = '0;

        unique case (state_reg)
            BK_IDLE: begin
                cmd_ready = out_free;
                if (cmd_valid && out_free) begin
                    emit = 1'b1;
                    if (halted_reg) begin
                        emit_ctl.action = ACT_HALTED;
                    end else begin
                        unique case (cmd_ctl.op)
                            OP_OFFER: begin
                                if (outstanding >= SEQ_BITS'(eff_window) || next_reg == '1) begin
                                    emit_ctl.action = ACT_REFUSED;
                                end else begin
                                    emit_ctl.action = ACT_SEND;
                                    emit_seq        = next_reg;
                                    next_next       = next_reg + 1'b1;
                                end
                            end
                            OP_ACK: begin
                                if (cmd_ctl.fin) begin
                                    halted_next     = 1'b1;
                                    emit_ctl.action = ACT_DONE;
                                end else begin
                                    if (cmd_ack >= base_reg && cmd_ack < next_reg) begin
                                        base_next = cmd_ack + 1'b1;
                                    end
                                    emit_ctl.action = ACT_ACKED;
                                end
                            end
                            OP_TIMEOUT: begin
                                if (base_reg == next_reg) begin
                                    emit_ctl.action = ACT_EMPTY;
                                end else if (base_reg == prior_reg && retry_inc >= cfg.retry_limit) begin
                                    retry_next      = retry_inc;
                                    halted_next     = 1'b1;
                                    emit_ctl.action = ACT_ABORT;
                                end else begin
                                    // start a retransmit run from base
                                    retry_next     = (base_reg == prior_reg) ? retry_inc : '0;
                                    prior_next     = base_reg;
                                    retx_seq_next  = base_reg;
                                    retx_left_next = retx_count;
                                    state_next     = BK_RETX;
                                    emit           = 1'b0;
                                end
                            end
                            default: begin
                                emit = 1'b0;
                            end
                        endcase
                    end
                end
            end
            BK_RETX: begin
                if (out_free) begin
                    emit            = 1'b1;
                    emit_ctl.action = ACT_RETX;
                    emit_ctl.last   = (retx_left_reg == CNT_W'(1));
                    emit_seq        = retx_seq_reg;
                    retx_seq_next   = retx_seq_reg + 1'b1;
                    retx_left_next  = retx_left_reg - 1'b1;
                    if (retx_left_reg == CNT_W'(1)) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !res_ready;
        m_ctl_next   = m_ctl_reg;
        m_seq_next   = m_seq_reg;
        m_base_next  = m_base_reg;
        m_next_next  = m_next_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_ctl_next   = emit_ctl;
            m_seq_next   = emit_seq;
            m_base_next  = base_next;
            m_next_next  = next_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            base_reg    <= '0;
            next_reg    <= '0;
            prior_reg   <= '0;
            retry_reg   <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            next_reg    <= next_next;
            prior_reg   <= prior_next;
            retry_reg   <= retry_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        retx_seq_reg  <= retx_seq_next;
        retx_left_reg <= retx_left_next;
        m_ctl_reg     <= m_ctl_next;
        m_seq_reg     <= m_seq_next;
        m_base_reg    <= m_base_next;
        m_next_reg    <= m_next_next;
    end

    assign res_valid = m_valid_reg;
    assign res_ctl   = m_ctl_reg;
    assign res_seq   = m_seq_reg;
    assign res_base  = m_base_reg;
    assign res_next  = m_next_reg;

endmodule

### rtl/go_back_n_sender_window_top.sv
// Go-Back-N sender window, top level: ports, configuration registers,
// front/queue/back wiring. Depends on gbn_pkg, gbn_front, gbn_queue, gbn_back.
//
// Each input beat is one event: an offer, an acknowledgment or a timeout
// (s_tuser), and each known kind yields one or more result beats on the m_
// side. Offers and acks give one result each; the back end takes one command
// per cycle while the output register drains and no retransmit run is under
// way, and a result passes the front register, the queue and the back-end
// output register before it is presented on m_tvalid. A timeout with
// N = min(next - base, WINDOW_MAX) numbers outstanding gives N retransmit
// beats and holds the back-end sequencer in its retransmit state until the
// last is out; that sequencer sets the rate under timeouts. A two-deep command
// queue separates the input side from the sequencer. Unknown kind codes are
// taken and dropped silently. After a final ack or an abort every event
// answers "halted" until reset. Configuration writes are taken at any time
// but are meant for an idle block; there is no clearing pass after reset.
`include "go_back_n_sender_window_top_defines.svh"

module go_back_n_sender_window_top #(
    parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF,
    parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF,
    localparam int IN_W  = 8 * ((SEQ_BITS + 1 + 7) / 8),
    localparam int OUT_W = 8 * ((3 + 3 * SEQ_BITS + 7) / 8)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // event input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,  // ack_seq, ack_final, zero pad
    input  logic [gbn_pkg::KIND_W-1:0]     s_tuser,  // kind
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,  // action, seq, window_base,
                                                     // window_next, zero pad
    output logic                           m_tlast,  // last result of the event
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gbn_pkg::*;

    localparam int PAD_W = OUT_W - (3 + 3 * SEQ_BITS);

    // configuration registers
    logic [WIN_W-1:0]   window_size_reg, window_size_next;
    logic [RETRY_W-1:0] retry_limit_reg, retry_limit_next;
    cfg_t               cfg;

    assign cfg_ready = 1'b1;

    always_comb begin
        window_size_next = window_size_reg;
        retry_limit_next = retry_limit_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE: window_size_next = cfg_data[WIN_W-1:0];
                CFG_RETRY_LIMIT: retry_limit_next = cfg_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_RESET;
            retry_limit_reg <= RETRY_RESET;
        end else begin
            window_size_reg <= window_size_next;
            retry_limit_reg <= retry_limit_next;
        end
    end

    assign cfg.window_size = window_size_reg;
    assign cfg.retry_limit = retry_limit_reg;

    // front end -> queue
    logic                fr_valid, fr_ready;
    cmd_ctl_t            fr_ctl;
    logic [SEQ_BITS-1:0] fr_ack;

    gbn_front #(.SEQ_BITS(SEQ_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_ack    (s_tdata[SEQ_BITS-1:0]),
        .in_fin    (s_tdata[SEQ_BITS]),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_ctl   (fr_ctl),
        .cmd_ack   (fr_ack)
    );

    // queue -> back end
    logic                q_valid, q_ready;
    cmd_ctl_t            q_ctl;
    logic [SEQ_BITS-1:0] q_ack;

    gbn_queue #(.SEQ_BITS(SEQ_BITS)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_ctl   (fr_ctl),
        .push_ack   (fr_ack),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_ctl    (q_ctl),
        .pop_ack    (q_ack)
    );

    // back end results
    res_ctl_t            out_ctl;
    logic [SEQ_BITS-1:0] out_seq, out_base, out_next;

    gbn_back #(.SEQ_BITS(SEQ_BITS), .WINDOW_MAX(WINDOW_MAX)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_ctl   (q_ctl),
        .cmd_ack   (q_ack),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_ctl   (out_ctl),
        .res_seq   (out_seq),
        .res_base  (out_base),
        .res_next  (out_next)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_next, out_base, out_seq, out_ctl.action};
    assign m_tlast = out_ctl.last;

    // base never passes next
    `GBN_ASSERT_IMP(a_base_le_next, m_tvalid, out_base <= out_next, "base beyond next")
    // retransmitted numbers lie inside the window
    `GBN_ASSERT_IMP(a_retx_in_window, m_tvalid && out_ctl.action == ACT_RETX,
                    out_seq >= out_base && out_seq < out_next, "retransmit outside window")
    // everything except a retransmit run is a single-beat answer
    `GBN_ASSERT_IMP(a_single_last, m_tvalid && out_ctl.action != ACT_RETX,
                    out_ctl.last, "single result without last")
    // a retransmit run continues without a gap
    `GBN_ASSERT_NXT(a_retx_no_gap,
                    m_tvalid && m_tready && out_ctl.action == ACT_RETX && !out_ctl.last,
                    m_tvalid && out_ctl.action == ACT_RETX, "gap in retransmit run")

endmodule
